// ===== src/fsjd_pkg.sv =====
// Shared types and codes of the fence signal job dispatcher.
package fsjd_pkg;

    localparam int ACTION_W = 3;
    localparam int HANDLE_W = 32;
    localparam int FSIG_W   = 9;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int QSTATE_W = 2;
    localparam int SIG_W    = 8;
    localparam int CNT_W    = 11;

    localparam logic [ACTION_W-1:0] ACT_JOB      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FENCE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUBMIT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_COMPLETE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ABORT    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GRANT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCK  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FINISH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

    localparam logic [QSTATE_W-1:0] RS_READY   = 2'd0;
    localparam logic [QSTATE_W-1:0] RS_QUEUED  = 2'd1;
    localparam logic [QSTATE_W-1:0] RS_DONE    = 2'd2;
    localparam logic [QSTATE_W-1:0] RS_ABORTED = 2'd3;

    localparam logic [FSIG_W-1:0] NEWEST_SIGNAL = 9'd256;
    localparam logic [SIG_W-1:0]  NO_SIGNAL     = 8'hFF;
    localparam logic [CNT_W-1:0]  CNT_MAX       = 11'd2047;

    typedef struct packed {
        logic                fence;
        logic [SIG_W-1:0]    sig;
        logic [HANDLE_W-1:0] data;
    } job_entry_t;

    localparam int ENTRY_W = $bits(job_entry_t);

endpackage

// ===== src/fsjd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fsjd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fence_signal_job_dispatcher_unit.sv =====
// Top level of the fence signal job dispatcher: sequencer around job and counter memories.
//
// Jobs and fences are appended to a job memory while the queue is ready; each job counts
// against the newest signal in a counter memory. Submit closes the list with a fence and
// starts the queue, dispatch walks it in order, complete decrements the job's signal.
// One item is worked at a time and gives exactly one result. Append, submit, abort, clear
// and dispatch of a job give their result from the execute state. Complete reads the job
// memory, then the counter memory, and writes the decrement. Dispatch reaching a fence
// reads its signal's counter, then blocks or finishes, or steps past it and reads the next
// entry. Both memories have registered reads. A new item is taken while the previous
// result waits in the output register; a result that cannot be handed over holds the unit.
module fence_signal_job_dispatcher_unit #(
    parameter int MAX_JOBS    = 1024,
    parameter int MAX_SIGNALS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fsjd_pkg::ACTION_W-1:0]   s_action,
    input  logic [fsjd_pkg::HANDLE_W-1:0]   s_job_handle,
    input  logic [fsjd_pkg::FSIG_W-1:0]     s_fence_signal,
    input  logic [fsjd_pkg::SLOT_W-1:0]     s_job_slot,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fsjd_pkg::STATUS_W-1:0]   m_status,
    output logic [fsjd_pkg::HANDLE_W-1:0]   m_granted_handle,
    output logic [fsjd_pkg::SLOT_W-1:0]     m_granted_slot,
    output logic [fsjd_pkg::QSTATE_W-1:0]   m_queue_state
);

    localparam int AW   = $clog2(MAX_JOBS);
    localparam int JC_W = $clog2(MAX_JOBS + 1);
    localparam int SW   = $clog2(MAX_SIGNALS);
    localparam int SC_W = $clog2(MAX_SIGNALS + 1);
    localparam int CW   = (JC_W > fsjd_pkg::SLOT_W) ? JC_W : fsjd_pkg::SLOT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FENCE = 3'd2;
    localparam logic [2:0] S_NEXT  = 3'd3;
    localparam logic [2:0] S_CPL   = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [JC_W-1:0]                 jc_reg, jc_next;
    logic [JC_W-1:0]                 ri_reg, ri_next;
    logic [SC_W-1:0]                 sc_reg, sc_next;
    logic [fsjd_pkg::QSTATE_W-1:0]   rs_reg, rs_next;
    logic                            last_fence_reg, last_fence_next;
    logic [fsjd_pkg::SIG_W-1:0]      last_sig_reg, last_sig_next;
    logic [fsjd_pkg::SIG_W-1:0]      sig_reg, sig_next;

    logic [fsjd_pkg::ACTION_W-1:0]   act_reg;
    logic [fsjd_pkg::HANDLE_W-1:0]   handle_reg;
    logic [fsjd_pkg::FSIG_W-1:0]     fsig_reg;
    logic [fsjd_pkg::SLOT_W-1:0]     slot_reg;

    logic                            m_valid_reg;
    logic [fsjd_pkg::STATUS_W-1:0]   status_reg;
    logic [fsjd_pkg::HANDLE_W-1:0]   ghandle_reg;
    logic [fsjd_pkg::SLOT_W-1:0]     gslot_reg;
    logic [fsjd_pkg::QSTATE_W-1:0]   qstate_reg;

    logic                            fin, out_free, commit, accept;
    logic [fsjd_pkg::STATUS_W-1:0]   res_status;
    logic [fsjd_pkg::HANDLE_W-1:0]   res_handle;
    logic [fsjd_pkg::SLOT_W-1:0]     res_slot;

    logic                            job_we, job_re;
    logic [AW-1:0]                   job_waddr, job_raddr;
    fsjd_pkg::job_entry_t            job_wdata, job_rdata;
    logic [fsjd_pkg::ENTRY_W-1:0]    job_rdata_raw;
    logic                            cnt_we, cnt_re;
    logic [SW-1:0]                   cnt_waddr, cnt_raddr;
    logic [fsjd_pkg::CNT_W-1:0]      cnt_wdata, cnt_rdata;

    logic [fsjd_pkg::SIG_W-1:0]      newest_sig;
    logic [fsjd_pkg::SIG_W-1:0]      req_sig;
    logic                            new_sig;
    logic [SC_W-1:0]                 cur_sig;
    logic [fsjd_pkg::CNT_W-1:0]      cur_cnt;
    logic [JC_W-1:0]                 ri_inc;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = !fin || out_free;
    assign s_ready  = (state_reg == S_IDLE);
    assign job_rdata = fsjd_pkg::job_entry_t'(job_rdata_raw);

    assign newest_sig = (sc_reg == '0) ? '0 : fsjd_pkg::SIG_W'(sc_reg - 1'b1);
    assign req_sig    = (fsig_reg == fsjd_pkg::NEWEST_SIGNAL) ? newest_sig
                                                              : fsig_reg[fsjd_pkg::SIG_W-1:0];
    assign new_sig    = (sc_reg == '0) ||
                        (last_fence_reg && (9'(last_sig_reg) == 9'(sc_reg) - 9'd1));
    assign cur_sig    = new_sig ? sc_reg : sc_reg - 1'b1;
    assign cur_cnt    = new_sig ? '0 : cnt_rdata;
    assign ri_inc     = ri_reg + 1'b1;

    always_comb begin
        state_next      = state_reg;
        jc_next         = jc_reg;
        ri_next         = ri_reg;
        sc_next         = sc_reg;
        rs_next         = rs_reg;
        last_fence_next = last_fence_reg;
        last_sig_next   = last_sig_reg;
        sig_next        = sig_reg;
        fin             = 1'b0;
        res_status      = fsjd_pkg::ST_REJECT;
        res_handle      = '0;
        res_slot        = '0;
        job_we          = 1'b0;
        job_waddr       = AW'(jc_reg);
        job_wdata       = '0;
        job_re          = 1'b0;
        job_raddr       = AW'(ri_reg);
        cnt_we          = 1'b0;
        cnt_waddr       = SW'(cur_sig);
        cnt_wdata       = cur_cnt + 1'b1;
        cnt_re          = 1'b0;
        cnt_raddr       = SW'(sc_reg - 1'b1);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    job_re = 1'b1;
                    cnt_re = 1'b1;
                    if (s_action == fsjd_pkg::ACT_COMPLETE) begin
                        job_raddr = AW'(s_job_slot);
                    end
                    if (s_action == fsjd_pkg::ACT_FENCE &&
                        s_fence_signal != fsjd_pkg::NEWEST_SIGNAL) begin
                        cnt_raddr = SW'(s_fence_signal[fsjd_pkg::SIG_W-1:0]);
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                fin = 1'b1;
                case (act_reg)
                    fsjd_pkg::ACT_JOB: begin
                        if (rs_reg == fsjd_pkg::RS_READY && jc_reg < JC_W'(MAX_JOBS) &&
                            !(new_sig && sc_reg >= SC_W'(MAX_SIGNALS)) &&
                            cur_cnt < fsjd_pkg::CNT_MAX) begin
                            job_we          = 1'b1;
                            job_wdata.fence = 1'b0;
                            job_wdata.sig   = fsjd_pkg::SIG_W'(cur_sig);
                            job_wdata.data  = handle_reg;
                            cnt_we          = 1'b1;
                            jc_next         = jc_reg + 1'b1;
                            sc_next         = new_sig ? sc_reg + 1'b1 : sc_reg;
                            last_fence_next = 1'b0;
                            res_status      = fsjd_pkg::ST_ACCEPT;
                        end
                    end
                    fsjd_pkg::ACT_FENCE: begin
                        if (rs_reg == fsjd_pkg::RS_READY && jc_reg < JC_W'(MAX_JOBS) &&
                            fsig_reg <= fsjd_pkg::NEWEST_SIGNAL &&
                            9'(req_sig) < 9'(sc_reg) && cnt_rdata != '0) begin
                            job_we          = 1'b1;
                            job_wdata.fence = 1'b1;
                            job_wdata.sig   = fsjd_pkg::NO_SIGNAL;
                            job_wdata.data  = fsjd_pkg::HANDLE_W'(req_sig);
                            jc_next         = jc_reg + 1'b1;
                            last_fence_next = 1'b1;
                            last_sig_next   = req_sig;
                            res_status      = fsjd_pkg::ST_ACCEPT;
                        end
                    end
                    fsjd_pkg::ACT_SUBMIT: begin
                        if (rs_reg == fsjd_pkg::RS_READY && jc_reg != '0 &&
                            (last_fence_reg || jc_reg < JC_W'(MAX_JOBS))) begin
                            if (!last_fence_reg) begin
                                job_we          = 1'b1;
                                job_wdata.fence = 1'b1;
                                job_wdata.sig   = fsjd_pkg::NO_SIGNAL;
                                job_wdata.data  = fsjd_pkg::HANDLE_W'(newest_sig);
                                jc_next         = jc_reg + 1'b1;
                                last_fence_next = 1'b1;
                                last_sig_next   = newest_sig;
                            end
                            rs_next    = fsjd_pkg::RS_QUEUED;
                            res_status = fsjd_pkg::ST_ACCEPT;
                        end
                    end
                    fsjd_pkg::ACT_DISPATCH: begin
                        if (rs_reg == fsjd_pkg::RS_READY) begin
                            res_status = fsjd_pkg::ST_REJECT;
                        end else if (rs_reg != fsjd_pkg::RS_QUEUED) begin
                            res_status = fsjd_pkg::ST_FINISH;
                        end else if (ri_reg >= jc_reg) begin
                            rs_next    = fsjd_pkg::RS_DONE;
                            res_status = fsjd_pkg::ST_FINISH;
                        end else if (!job_rdata.fence) begin
                            res_status = fsjd_pkg::ST_GRANT;
                            res_handle = job_rdata.data;
                            res_slot   = fsjd_pkg::SLOT_W'(ri_reg);
                            ri_next    = ri_inc;
                        end else begin
                            fin        = 1'b0;
                            cnt_re     = 1'b1;
                            cnt_raddr  = SW'(job_rdata.data[fsjd_pkg::SIG_W-1:0]);
                            sig_next   = job_rdata.data[fsjd_pkg::SIG_W-1:0];
                            state_next = S_FENCE;
                        end
                    end
                    fsjd_pkg::ACT_COMPLETE: begin
                        if (rs_reg != fsjd_pkg::RS_READY &&
                            CW'(slot_reg) < CW'(jc_reg) && CW'(slot_reg) < CW'(ri_reg) &&
                            !job_rdata.fence && 9'(job_rdata.sig) < 9'(sc_reg)) begin
                            fin        = 1'b0;
                            cnt_re     = 1'b1;
                            cnt_raddr  = SW'(job_rdata.sig);
                            sig_next   = job_rdata.sig;
                            state_next = S_CPL;
                        end
                    end
                    fsjd_pkg::ACT_ABORT: begin
                        if (rs_reg != fsjd_pkg::RS_READY) begin
                            rs_next    = fsjd_pkg::RS_ABORTED;
                            res_status = fsjd_pkg::ST_ACCEPT;
                        end
                    end
                    fsjd_pkg::ACT_CLEAR: begin
                        if (rs_reg != fsjd_pkg::RS_QUEUED) begin
                            jc_next         = '0;
                            sc_next         = '0;
                            ri_next         = '0;
                            rs_next         = fsjd_pkg::RS_READY;
                            last_fence_next = 1'b0;
                            res_status      = fsjd_pkg::ST_ACCEPT;
                        end
                    end
                    default: begin
                        res_status = fsjd_pkg::ST_REJECT;
                    end
                endcase
                if (fin) begin
                    state_next = S_IDLE;
                end
            end
            S_FENCE: begin
                if (9'(sig_reg) < 9'(sc_reg) && cnt_rdata != '0) begin
                    fin        = 1'b1;
                    res_status = fsjd_pkg::ST_BLOCK;
                    state_next = S_IDLE;
                end else if (ri_inc >= jc_reg) begin
                    fin        = 1'b1;
                    ri_next    = ri_inc;
                    rs_next    = fsjd_pkg::RS_DONE;
                    res_status = fsjd_pkg::ST_FINISH;
                    state_next = S_IDLE;
                end else begin
                    ri_next    = ri_inc;
                    job_re     = 1'b1;
                    job_raddr  = AW'(ri_inc);
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                fin        = 1'b1;
                state_next = S_IDLE;
                if (job_rdata.fence) begin
                    res_status = fsjd_pkg::ST_BLOCK;
                end else begin
                    res_status = fsjd_pkg::ST_GRANT;
                    res_handle = job_rdata.data;
                    res_slot   = fsjd_pkg::SLOT_W'(ri_reg);
                    ri_next    = ri_inc;
                end
            end
            S_CPL: begin
                fin        = 1'b1;
                state_next = S_IDLE;
                if (cnt_rdata != '0) begin
                    cnt_we     = 1'b1;
                    cnt_waddr  = SW'(sig_reg);
                    cnt_wdata  = cnt_rdata - 1'b1;
                    res_status = fsjd_pkg::ST_ACCEPT;
                    res_slot   = slot_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            jc_reg         <= '0;
            ri_reg         <= '0;
            sc_reg         <= '0;
            rs_reg         <= fsjd_pkg::RS_READY;
            last_fence_reg <= 1'b0;
            last_sig_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (commit) begin
                state_reg      <= state_next;
                jc_reg         <= jc_next;
                ri_reg         <= ri_next;
                sc_reg         <= sc_next;
                rs_reg         <= rs_next;
                last_fence_reg <= last_fence_next;
                last_sig_reg   <= last_sig_next;
            end
            if (fin && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= s_action;
            handle_reg <= s_job_handle;
            fsig_reg   <= s_fence_signal;
            slot_reg   <= s_job_slot;
        end
        if (commit) begin
            sig_reg <= sig_next;
        end
        if (fin && out_free) begin
            status_reg  <= res_status;
            ghandle_reg <= res_handle;
            gslot_reg   <= res_slot;
            qstate_reg  <= rs_next;
        end
    end

    fsjd_ram #(
        .WIDTH (fsjd_pkg::ENTRY_W),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .aclk  (aclk),
        .we    (job_we && commit),
        .waddr (job_waddr),
        .wdata (job_wdata),
        .re    (job_re),
        .raddr (job_raddr),
        .rdata (job_rdata_raw)
    );

    fsjd_ram #(
        .WIDTH (fsjd_pkg::CNT_W),
        .DEPTH (MAX_SIGNALS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we && commit),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_granted_handle = ghandle_reg;
    assign m_granted_slot   = gslot_reg;
    assign m_queue_state    = qstate_reg;

`ifndef SYNTHESIS
    a_jc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        jc_reg <= JC_W'(MAX_JOBS))
        else $error("job count beyond table depth");

    a_ri_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ri_reg <= jc_reg)
        else $error("read index past job count");

    a_sc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sc_reg <= SC_W'(MAX_SIGNALS)) && (jc_reg == '0 || sc_reg != '0))
        else $error("signal count inconsistent with job table");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !job_we && !cnt_we)
        else $error("memory write while idle");

    a_done_after_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(rs_reg) == fsjd_pkg::RS_READY && rs_reg != fsjd_pkg::RS_READY)
        |-> rs_reg == fsjd_pkg::RS_QUEUED && last_fence_reg)
        else $error("queue left ready without a closing fence");
`endif

endmodule
